// ===== rtl/core/fiur_pkg.sv =====
// ----------------------------------------------------------------------------
// fiur_pkg
// Shared types and constants for the frame interval union residual block.
// ----------------------------------------------------------------------------
package fiur_pkg;

  localparam int FIELD_W = 48;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SWEEP = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } fiur_state_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } fiur_ctl_t;

endpackage

// ===== rtl/core/frame_interval_union_residual.sv =====
// ----------------------------------------------------------------------------
// frame_interval_union_residual
// A request that does not end a frame leaves busy low.
// A request with last_of_frame raises busy: the chain shifts one span per
// cycle into the sweep unit, then the drain and emit states finish the sum
// and subtraction. out_valid pulses one cycle as busy falls, if a frame span was seen.
// Synchronous active-low reset empties the chain and clears the frame state.
// ----------------------------------------------------------------------------
module frame_interval_union_residual import fiur_pkg::*; #(
  parameter int MAX_SPANS = 64,
  parameter int TIME_BITS = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [FIELD_W-1:0] in_span_start,
  input  logic [FIELD_W-1:0] in_span_end,
  input  logic               in_is_frame_span,
  input  logic               in_last_of_frame,
  output logic               out_valid,
  output logic [FIELD_W-1:0] out_residual_time,
  output logic               out_spans_dropped
);

  localparam int TW = TIME_BITS;

  fiur_state_t   state_r, state_nxt;
  fiur_ctl_t     ctl;
  logic          accept;
  logic [TW-1:0] new_s, new_e;

  logic [MAX_SPANS-1:0] vld, g;
  logic [TW-1:0]        cs [MAX_SPANS];
  logic [TW-1:0]        ce [MAX_SPANS];

  logic          frame_seen_r, frame_seen_nxt;
  logic          ovf_r, ovf_nxt;
  logic [TW-1:0] fs_r, fs_nxt;
  logic [TW-1:0] fe_r, fe_nxt;

  logic [TW-1:0] cursor_r, delta_r, covered_r, len_r;
  logic [TW-1:0] lo, hi;
  logic          hit;

  logic               out_valid_r;
  logic [FIELD_W-1:0] out_res_r;
  logic               out_drop_r;

  assign new_s  = TW'(in_span_start);
  assign new_e  = TW'(in_span_end);
  assign busy   = (state_r != ST_IDLE);
  assign accept = start & ~busy;

  assign ctl.ins   = accept & ~in_is_frame_span & ~vld[MAX_SPANS-1];
  assign ctl.shift = (state_r == ST_SWEEP) & vld[0];

  for (genvar i = 0; i < MAX_SPANS; i++) begin : g_cell
    logic          lg, lv, rv;
    logic [TW-1:0] ls, le, rs, re;
    if (i == 0) begin : g_head
      assign lg = 1'b0;
      assign lv = 1'b0;
      assign ls = '0;
      assign le = '0;
    end else begin : g_mid
      assign lg = g[i-1];
      assign lv = vld[i-1];
      assign ls = cs[i-1];
      assign le = ce[i-1];
    end
    if (i == MAX_SPANS - 1) begin : g_tail
      assign rv = 1'b0;
      assign rs = '0;
      assign re = '0;
    end else begin : g_body
      assign rv = vld[i+1];
      assign rs = cs[i+1];
      assign re = ce[i+1];
    end
    fiur_cell #(.TW(TW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .new_s     (new_s),
      .new_e     (new_e),
      .left_g    (lg),
      .left_vld  (lv),
      .left_s    (ls),
      .left_e    (le),
      .right_vld (rv),
      .right_s   (rs),
      .right_e   (re),
      .g         (g[i]),
      .vld       (vld[i]),
      .s         (cs[i]),
      .e         (ce[i])
    );
  end

  always_comb begin
    frame_seen_nxt = frame_seen_r;
    ovf_nxt        = ovf_r;
    fs_nxt         = fs_r;
    fe_nxt         = fe_r;
    if (accept) begin
      if (in_is_frame_span) begin
        if (!frame_seen_r) begin
          frame_seen_nxt = 1'b1;
          fs_nxt         = new_s;
          fe_nxt         = new_e;
        end
      end else if (vld[MAX_SPANS-1]) begin
        ovf_nxt = 1'b1;
      end
    end
    if (state_r == ST_EMIT) begin
      frame_seen_nxt = 1'b0;
      ovf_nxt        = 1'b0;
      fs_nxt         = '0;
      fe_nxt         = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept && in_last_of_frame) state_nxt = ST_SWEEP;
      ST_SWEEP: if (!vld[0]) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_EMIT;
      ST_EMIT:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign lo  = (cs[0] > cursor_r) ? cs[0] : cursor_r;
  assign hi  = (ce[0] < fe_r) ? ce[0] : fe_r;
  assign hit = hi > lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      frame_seen_r <= 1'b0;
      ovf_r        <= 1'b0;
      fs_r         <= '0;
      fe_r         <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      frame_seen_r <= frame_seen_nxt;
      ovf_r        <= ovf_nxt;
      fs_r         <= fs_nxt;
      fe_r         <= fe_nxt;
      out_valid_r  <= (state_r == ST_EMIT) & frame_seen_r;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        cursor_r  <= fs_nxt;
        delta_r   <= '0;
        covered_r <= '0;
      end
      ST_SWEEP: begin
        covered_r <= covered_r + delta_r;
        if (vld[0] && hit) begin
          delta_r  <= hi - lo;
          cursor_r <= hi;
        end else begin
          delta_r <= '0;
        end
      end
      ST_DRAIN: begin
        covered_r <= covered_r + delta_r;
        delta_r   <= '0;
        len_r     <= (fe_r >= fs_r) ? (fe_r - fs_r) : '0;
      end
      ST_EMIT: begin
        out_res_r  <= FIELD_W'(len_r - covered_r);
        out_drop_r <= ovf_r;
      end
      default: begin
        delta_r <= '0;
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_residual_time = out_res_r;
  assign out_spans_dropped = out_drop_r;

endmodule

// ===== rtl/core/fiur_cell.sv =====
// ----------------------------------------------------------------------------
// fiur_cell
// One slot of the sorted span chain. Compares the broadcast span against its
// own, takes it, takes its left neighbor or holds on insert; takes its right
// neighbor on sweep shift.
// ----------------------------------------------------------------------------
module fiur_cell import fiur_pkg::*; #(
  parameter int TW = 48
) (
  input  logic          clk,
  input  logic          rst_n,
  input  fiur_ctl_t     ctl,
  input  logic [TW-1:0] new_s,
  input  logic [TW-1:0] new_e,
  input  logic          left_g,
  input  logic          left_vld,
  input  logic [TW-1:0] left_s,
  input  logic [TW-1:0] left_e,
  input  logic          right_vld,
  input  logic [TW-1:0] right_s,
  input  logic [TW-1:0] right_e,
  output logic          g,
  output logic          vld,
  output logic [TW-1:0] s,
  output logic [TW-1:0] e
);

  logic          vld_r;
  logic [TW-1:0] s_r;
  logic [TW-1:0] e_r;

  assign g   = ~vld_r || (s_r > new_s) || ((s_r == new_s) && (e_r > new_e));
  assign vld = vld_r;
  assign s   = s_r;
  assign e   = e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.shift) begin
      vld_r <= right_vld;
    end else if (ctl.ins) begin
      if (left_g) begin
        vld_r <= left_vld;
      end else if (g) begin
        vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      s_r <= right_s;
      e_r <= right_e;
    end else if (ctl.ins) begin
      if (left_g) begin
        s_r <= left_s;
        e_r <= left_e;
      end else if (g) begin
        s_r <= new_s;
        e_r <= new_e;
      end
    end
  end

endmodule

// ===== rtl/core/fiur_chk.sv =====
// ----------------------------------------------------------------------------
// fiur_chk
// Port-level checks on request acceptance, busy and the result strobe.
// ----------------------------------------------------------------------------
module fiur_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_last_of_frame,
  input logic out_valid
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("busy or strobe after reset");

  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last_of_frame |=> busy)
    else $error("frame end request did not start the sweep");

  a_inner_free: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_last_of_frame |=> !busy)
    else $error("plain request held busy");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result strobe outside end of sweep");

endmodule

bind frame_interval_union_residual fiur_chk u_fiur_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_last_of_frame (in_last_of_frame),
  .out_valid        (out_valid)
);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for frame_interval_union_residual. Frames of timed spans
// go in as requests with random gaps between them. A behavioral copy of the
// sorted span chain and the clipped union sweep predicts each frame residual.
// Every strobed result is compared in order against those predictions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import fiur_pkg::*;

localparam int SPAN_CAPACITY = 64;

typedef struct packed {
  logic [FIELD_W-1:0] residual;
  logic               dropped;
} residual_t;

typedef struct packed {
  logic [FIELD_W-1:0] t_start;
  logic [FIELD_W-1:0] t_end;
  logic               is_frame;
  logic               last;
} span_req_t;

class residual_book;
  logic [FIELD_W-1:0] chain_start [SPAN_CAPACITY];
  logic [FIELD_W-1:0] chain_end [SPAN_CAPACITY];
  int unsigned        chain_len;
  logic [FIELD_W-1:0] frame_lo;
  logic [FIELD_W-1:0] frame_hi;
  bit                 frame_seen;
  bit                 overflow;
  residual_t          pending_residuals[$];
  int unsigned        mismatches;
  int unsigned        results;
  int unsigned        dropped_frames;
  int unsigned        requests;

  function new();
    clear_frame();
    mismatches = 0;
    results = 0;
    dropped_frames = 0;
    requests = 0;
  endfunction

  function void clear_frame();
    chain_len = 0;
    frame_lo = '0;
    frame_hi = '0;
    frame_seen = 1'b0;
    overflow = 1'b0;
  endfunction

  function void insert_inner(logic [FIELD_W-1:0] s, logic [FIELD_W-1:0] e);
    int unsigned pos;
    if (chain_len >= SPAN_CAPACITY) begin
      overflow = 1'b1;
      return;
    end
    pos = chain_len;
    while (pos > 0 && !(chain_start[pos-1] < s ||
                        (chain_start[pos-1] == s && chain_end[pos-1] <= e))) begin
      chain_start[pos] = chain_start[pos-1];
      chain_end[pos] = chain_end[pos-1];
      pos--;
    end
    chain_start[pos] = s;
    chain_end[pos] = e;
    chain_len++;
  endfunction

  function logic [FIELD_W-1:0] sweep_residual();
    logic [FIELD_W-1:0] covered;
    logic [FIELD_W-1:0] cursor;
    logic [FIELD_W-1:0] lo;
    logic [FIELD_W-1:0] hi;
    covered = '0;
    cursor = frame_lo;
    if (frame_hi < frame_lo) return '0;
    for (int i = 0; i < chain_len; i++) begin
      lo = (chain_start[i] > cursor) ? chain_start[i] : cursor;
      hi = (chain_end[i] < frame_hi) ? chain_end[i] : frame_hi;
      if (hi > lo) begin
        covered = covered + (hi - lo);
        cursor = hi;
      end
    end
    return (frame_hi - frame_lo) - covered;
  endfunction

  function void take_span(span_req_t r);
    residual_t x;
    requests++;
    if (r.is_frame) begin
      if (!frame_seen) begin
        frame_seen = 1'b1;
        frame_lo = r.t_start;
        frame_hi = r.t_end;
      end
    end else begin
      insert_inner(r.t_start, r.t_end);
    end
    if (r.last) begin
      if (frame_seen) begin
        x.residual = sweep_residual();
        x.dropped = overflow;
        pending_residuals.insert(pending_residuals.size(), x);
        if (overflow) dropped_frames++;
      end
      clear_frame();
    end
  endfunction

  function void match_residual(logic [FIELD_W-1:0] residual, logic dropped);
    residual_t x;
    results++;
    if (pending_residuals.size() == 0) begin
      $display("%0t: unexpected result residual=%0d dropped=%0b", $time, residual, dropped);
      mismatches++;
      return;
    end
    x = pending_residuals.pop_front();
    if (residual !== x.residual) begin
      $display("%0t: residual_time expected %0d actual %0d", $time, x.residual, residual);
      mismatches++;
    end
    if (dropped !== x.dropped) begin
      $display("%0t: spans_dropped expected %0b actual %0b", $time, x.dropped, dropped);
      mismatches++;
    end
  endfunction
endclass

module tb;

  localparam int ITEMS       = 1750;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [FIELD_W-1:0] T_MAX = {FIELD_W{1'b1}};

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [FIELD_W-1:0] in_span_start = '0;
  logic [FIELD_W-1:0] in_span_end = '0;
  logic               in_is_frame_span = 1'b0;
  logic               in_last_of_frame = 1'b0;
  logic               out_valid;
  logic [FIELD_W-1:0] out_residual_time;
  logic               out_spans_dropped;

  residual_book book = new();
  span_req_t    frame_q[$];
  bit           burst = 1'b0;
  int unsigned  sent = 0;
  int unsigned  cycles = 0;

  frame_interval_union_residual dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_span_start    (in_span_start),
    .in_span_end      (in_span_end),
    .in_is_frame_span (in_is_frame_span),
    .in_last_of_frame (in_last_of_frame),
    .out_valid        (out_valid),
    .out_residual_time(out_residual_time),
    .out_spans_dropped(out_spans_dropped)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) book.match_residual(out_residual_time, out_spans_dropped);
      if (start && !busy)
        book.take_span('{in_span_start, in_span_end, in_is_frame_span, in_last_of_frame});
    end
  end

  function automatic logic [FIELD_W-1:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[FIELD_W-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] pick_extreme();
    case ($urandom_range(0, 2))
      0: return '0;
      1: return T_MAX;
      default: return rand48();
    endcase
  endfunction

  task automatic add(logic [FIELD_W-1:0] s, logic [FIELD_W-1:0] e, logic f, logic l);
    span_req_t r;
    r = '{s, e, f, l};
    frame_q.insert(frame_q.size(), r);
  endtask

  task automatic send_span(span_req_t r);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_span_start <= r.t_start;
    in_span_end <= r.t_end;
    in_is_frame_span <= r.is_frame;
    in_last_of_frame <= r.last;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_span(frame_q[i]);
    frame_q.delete();
  endtask

  task automatic make_frame(int idx);
    int                 n_inner;
    int                 style;
    logic [FIELD_W-1:0] base;
    logic [FIELD_W-1:0] len;
    logic [FIELD_W-1:0] s;
    logic [FIELD_W-1:0] e;
    span_req_t          r;
    style = $urandom_range(0, 99);
    n_inner = (idx % 23 == 11) ? int'($urandom_range(SPAN_CAPACITY - 2, SPAN_CAPACITY + 6))
                               : int'($urandom_range(0, 9));
    base = rand48() >> 1;
    len = FIELD_W'($urandom_range(1, 1 << 16));
    for (int i = 0; i < n_inner; i++) begin
      if (style < 10) begin
        s = rand48();
        e = rand48();
      end else if (style < 14) begin
        s = pick_extreme();
        e = pick_extreme();
      end else begin
        s = base + FIELD_W'($urandom_range(0, 32'(len) + 512)) - FIELD_W'(256);
        e = s + FIELD_W'($urandom_range(0, 32'(len) / 2));
        if ($urandom_range(0, 19) == 0) e = s - FIELD_W'($urandom_range(1, 100));
      end
      add(s, e, 1'b0, 1'b0);
    end
    if ($urandom_range(0, 9) != 0) begin
      // place the frame span anywhere in the frame
      if (style < 10) begin
        r = '{rand48(), rand48(), 1'b1, 1'b0};
      end else if (style < 14) begin
        r = '{pick_extreme(), pick_extreme(), 1'b1, 1'b0};
      end else if ($urandom_range(0, 24) == 0) begin
        r = '{base + len, base, 1'b1, 1'b0};
      end else begin
        r = '{base, base + len, 1'b1, 1'b0};
      end
      frame_q.insert($urandom_range(0, frame_q.size()), r);
      if ($urandom_range(0, 9) == 0)
        frame_q.insert($urandom_range(0, frame_q.size()), '{rand48(), rand48(), 1'b1, 1'b0});
    end
    if (frame_q.size() == 0) add(base, base + len, 1'b0, 1'b0);
    frame_q[frame_q.size() - 1].last = 1'b1;
  endtask

  initial begin
    int frame_idx;
    frame_idx = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // frame span alone over the full range
    add('0, T_MAX, 1'b1, 1'b1);
    send_frame();
    // inner span covers the whole frame
    add('0, T_MAX, 1'b1, 1'b0);
    add('0, T_MAX, 1'b0, 1'b1);
    send_frame();
    // no frame span: no result
    add(48'd10, 48'd20, 1'b0, 1'b0);
    add(48'd30, 48'd40, 1'b0, 1'b1);
    send_frame();
    // second frame span is ignored
    add(48'd100, 48'd200, 1'b1, 1'b0);
    add(48'd0, 48'd1000, 1'b1, 1'b0);
    add(48'd150, 48'd180, 1'b0, 1'b1);
    send_frame();
    // reversed frame
    add(48'd500, 48'd100, 1'b1, 1'b0);
    add(48'd200, 48'd300, 1'b0, 1'b1);
    send_frame();
    // clipping, overlap, empty and reversed inner spans, out-of-order arrival
    add(48'd1900, 48'd3000, 1'b0, 1'b0);
    add(48'd1000, 48'd2000, 1'b1, 1'b0);
    add(48'd1100, 48'd1500, 1'b0, 1'b0);
    add(48'd500, 48'd1200, 1'b0, 1'b0);
    add(48'd1400, 48'd1400, 1'b0, 1'b0);
    add(48'd1700, 48'd1600, 1'b0, 1'b1);
    send_frame();
    // spans at the top of the range, frame span ends the frame
    add(T_MAX, T_MAX, 1'b0, 1'b0);
    add(T_MAX - 5, T_MAX, 1'b1, 1'b1);
    send_frame();

    while (sent < ITEMS) begin
      burst = ($urandom_range(0, 3) == 0);
      make_frame(frame_idx);
      send_frame();
      frame_idx++;
    end
    start <= 1'b0;

    while (book.pending_residuals.size() != 0) @(posedge clk);
    repeat (SPAN_CAPACITY + 16) @(posedge clk);

    $display("%0d requests in %0d random frames plus directed cases", book.requests, frame_idx);
    $display("%0d residuals checked, %0d with dropped spans, %0d mismatches",
             book.results, book.dropped_frames, book.mismatches);
    if (book.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
